// ===== rtl/address_lease_table_top_defines.svh =====
// Assertion macros for the lease table.
`ifndef ADDRESS_LEASE_TABLE_TOP_DEFINES_SVH
`define ADDRESS_LEASE_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ALT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ALT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ALT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ALT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/alt_pkg.sv =====
`default_nettype none
package alt_pkg;
    localparam int PoolEntries = 256;
    localparam int IdxW = $clog2(PoolEntries);
    localparam int CntW = $clog2(PoolEntries + 1);

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_CHECK = 3'd1;
    localparam logic [2:0] OP_SET_USED = 3'd2;
    localparam logic [2:0] OP_BIND = 3'd3;
    localparam logic [2:0] OP_REQUEST = 3'd4;
    localparam logic [2:0] OP_FIND_FREE = 3'd5;

    localparam logic [1:0] TAG_REAL = 2'd0;
    localparam logic [1:0] TAG_ZERO = 2'd1;
    localparam logic [1:0] TAG_UNKNOWN = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] lease_address;
        logic [47:0] client_mac;
        logic [1:0]  mac_tag;
        logic [31:0] now_seconds;
        logic [31:0] lifetime_seconds;
        logic [31:0] expiry_seconds;
        logic        used_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_address;
        logic        renew_refused;
    } out_item_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [1:0]  tag;
        logic [31:0] lifetime;
        logic [31:0] expiry;
        logic        in_use;
    } slot_rec_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic            capture;   // latch input item
        logic            rd_en;     // read slot at rd_idx
        logic [IdxW-1:0] rd_idx;
        logic            load_wr;   // append entry at filled count
        logic            upd_wr;    // write back updated slot at hit index
        logic            finish;    // form result
        logic            hit;       // a slot was found
        logic [IdxW-1:0] hit_idx;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [2:0]      opcode;
        logic            match;     // registered read slot matches
        logic [CntW-1:0] filled;
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== rtl/alt_datapath.sv =====
`default_nettype none
module alt_datapath
    import alt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t in_data,
    input  wire dp_cmd_t  cmd,
    output dp_stat_t      stat,
    output out_item_t     result
);
    logic [31:0] addr_mem [PoolEntries];
    slot_rec_t   rec_mem [PoolEntries];
    in_item_t    item_reg;
    logic [31:0] rd_addr_reg;
    slot_rec_t   rd_rec_reg;
    logic        rd_valid_reg;
    logic [CntW-1:0] filled_reg, filled_next;
    slot_rec_t   hit_rec_reg;
    logic [31:0] hit_addr_reg;
    out_item_t   result_reg, result_next;
    slot_rec_t   new_rec;
    logic [1:0]  load_tag;
    logic [32:0] sum;
    logic        match;

    assign match = rd_valid_reg && ((item_reg.opcode == OP_FIND_FREE) ?
                   !rd_rec_reg.in_use : (rd_addr_reg == item_reg.lease_address));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.rd_en)
        begin
            rd_addr_reg <= addr_mem[cmd.rd_idx];
            rd_rec_reg  <= rec_mem[cmd.rd_idx];
        end
        if (match)
        begin
            hit_rec_reg  <= rd_rec_reg;
            hit_addr_reg <= rd_addr_reg;
        end
        if (cmd.load_wr)
        begin
            addr_mem[filled_reg[IdxW-1:0]] <= item_reg.lease_address;
            rec_mem[filled_reg[IdxW-1:0]]  <= new_rec;
        end
        else if (cmd.upd_wr)
        begin
            rec_mem[cmd.hit_idx] <= new_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            filled_reg   <= '0;
            result_reg   <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            filled_reg   <= filled_next;
            if (cmd.finish)
            begin
                result_reg <= result_next;
            end
        end
    end

    always_comb
    begin
        filled_next = filled_reg;
        if (cmd.load_wr)
        begin
            filled_next = filled_reg + 1'b1;
        end
    end

    always_comb
    begin
        load_tag = (item_reg.mac_tag == 2'd3) ? TAG_UNKNOWN : item_reg.mac_tag;
        sum = {1'b0, item_reg.now_seconds} + {1'b0, hit_rec_reg.lifetime};
        new_rec = hit_rec_reg;
        case (item_reg.opcode)
            OP_LOAD:
            begin
                new_rec.mac      = (load_tag == TAG_REAL) ? item_reg.client_mac : '0;
                new_rec.tag      = load_tag;
                new_rec.lifetime = item_reg.lifetime_seconds;
                new_rec.expiry   = item_reg.expiry_seconds;
                new_rec.in_use   = item_reg.used_value;
            end
            OP_SET_USED:
            begin
                new_rec.mac    = '0;
                new_rec.tag    = item_reg.used_value ? TAG_UNKNOWN : TAG_ZERO;
                new_rec.in_use = item_reg.used_value;
            end
            OP_BIND:
            begin
                new_rec.mac    = item_reg.client_mac;
                new_rec.tag    = TAG_REAL;
                new_rec.in_use = 1'b1;
                new_rec.expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            default:
            begin
                new_rec = hit_rec_reg;
            end
        endcase
    end

    // The result is formed in the finish cycle, before a load bumps the fill count.
    always_comb
    begin
        result_next = '0;
        case (item_reg.opcode)
            OP_LOAD:
            begin
                result_next.status = (filled_reg >= CntW'(PoolEntries)) ? ST_FULL : ST_DONE;
            end
            OP_CHECK:
            begin
                result_next.status = cmd.hit ? ST_DONE : ST_MISS;
                result_next.renew_refused = !(cmd.hit && hit_rec_reg.tag == TAG_REAL &&
                    hit_rec_reg.mac == item_reg.client_mac &&
                    item_reg.now_seconds <= hit_rec_reg.expiry);
            end
            OP_SET_USED, OP_BIND:
            begin
                result_next.status = cmd.hit ? ST_DONE : ST_MISS;
            end
            OP_REQUEST:
            begin
                if (cmd.hit && !hit_rec_reg.in_use)
                begin
                    result_next.result_address = item_reg.lease_address;
                end
                else
                begin
                    result_next.status = ST_MISS;
                end
            end
            OP_FIND_FREE:
            begin
                if (cmd.hit)
                begin
                    result_next.result_address = hit_addr_reg;
                end
                else
                begin
                    result_next.status = ST_MISS;
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    assign result      = result_reg;
    assign stat.opcode = item_reg.opcode;
    assign stat.match  = match;
    assign stat.filled = filled_reg;
endmodule
`default_nettype wire

// ===== rtl/alt_controller.sv =====
`default_nettype none
module alt_controller
    import alt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);
    typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_SCAN, S_FINISH, S_OUT} state_t;

    state_t state_reg, state_next;
    logic [CntW-1:0] idx_reg, idx_next;     // next slot to read
    logic [IdxW-1:0] hit_idx_reg, hit_idx_next;
    logic            hit_reg, hit_next;
    logic            pend_reg, pend_next;   // a read is in flight
    logic            out_valid_next;
    logic            write_back;

    assign in_stall = (state_reg != S_IDLE);
    assign write_back = (stat.opcode == OP_SET_USED) || (stat.opcode == OP_BIND);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        hit_idx_next   = hit_idx_reg;
        hit_next       = hit_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid;
        cmd            = '0;
        cmd.rd_idx     = idx_reg[IdxW-1:0];
        cmd.hit        = hit_reg;
        cmd.hit_idx    = hit_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                idx_next = '0;
                hit_next = 1'b0;
                if (stat.opcode == OP_LOAD || stat.opcode > OP_FIND_FREE)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (pend_reg && stat.match)
                begin
                    hit_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else if (idx_reg < stat.filled)
                begin
                    cmd.rd_en = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    hit_idx_next = idx_reg[IdxW-1:0];
                end
                else if (!pend_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish  = 1'b1;
                cmd.load_wr = (stat.opcode == OP_LOAD) &&
                              (stat.filled < CntW'(PoolEntries));
                cmd.upd_wr  = hit_reg && write_back;
                out_valid_next = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            hit_idx_reg <= '0;
            hit_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            out_valid   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            hit_idx_reg <= hit_idx_next;
            hit_reg     <= hit_next;
            pend_reg    <= pend_next;
            out_valid   <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/address_lease_table_top.sv =====
// Lease table: one item in, one result item out, one item in the block at a
// time. Searches visit filled slots in order, one slot per cycle through the
// registered slot memory read port, and stop at the first match. A load or an
// unknown opcode skips the search and goes straight to the result; a search
// that misses visits every filled slot. An output stall holds the result
// item, and no new item is taken until it leaves.
`default_nettype none
`include "address_lease_table_top_defines.svh"
module address_lease_table_top
    import alt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller sequences the scan; the datapath holds the slots.
    alt_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    alt_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .result  (out_data)
    );

    // A table write never happens while a result item is being shown.
    `ALT_ASSERT_IMPL(a_no_write_on_out, clk, rst_n, out_valid, !(cmd.load_wr || cmd.upd_wr))
    // The fill count never exceeds the table size.
    `ALT_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, stat.filled <= CntW'(PoolEntries))
    // No new item is taken while a result item waits.
    `ALT_ASSERT_IMPL(a_stall_out, clk, rst_n, out_valid, in_stall)
endmodule
`default_nettype wire

// ===== tb/sv/lease_table_checker.sv =====
`default_nettype none
module lease_table_checker
    import alt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_stall,
    input  wire in_item_t  in_data,
    input  wire logic      out_valid,
    input  wire logic      out_stall,
    input  wire out_item_t out_data,
    output int             fail_count,
    output int             pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] lease_addr [PoolEntries];
    logic [47:0] lease_mac [PoolEntries];
    logic [1:0]  lease_tag [PoolEntries];
    logic [31:0] lease_life [PoolEntries];
    logic [31:0] lease_expiry [PoolEntries];
    logic        lease_used [PoolEntries];
    int          lease_count;
    out_item_t   expected_results [$];

    function automatic int first_lease(logic [31:0] addr);
        for (int i = 0; i < lease_count; i++)
            if (lease_addr[i] == addr)
                return i;
        return -1;
    endfunction

    // Applies one item to the shadow table and returns the result it should give.
    function automatic out_item_t apply_lease_op(in_item_t item);
        out_item_t  res;
        int         hit;
        logic [32:0] sum;
        logic [1:0] tag;
        res = '0;
        hit = first_lease(item.lease_address);
        case (item.opcode)
            OP_LOAD:
            begin
                if (lease_count >= PoolEntries)
                    res.status = ST_FULL;
                else
                begin
                    tag = (item.mac_tag == 2'd3) ? TAG_UNKNOWN : item.mac_tag;
                    lease_addr[lease_count] = item.lease_address;
                    lease_mac[lease_count] = (tag == TAG_REAL) ? item.client_mac : '0;
                    lease_tag[lease_count] = tag;
                    lease_life[lease_count] = item.lifetime_seconds;
                    lease_expiry[lease_count] = item.expiry_seconds;
                    lease_used[lease_count] = item.used_value;
                    lease_count++;
                end
            end
            OP_CHECK:
            begin
                if (hit < 0)
                begin
                    res.status = ST_MISS;
                    res.renew_refused = 1'b1;
                end
                else
                    res.renew_refused = !(lease_tag[hit] == TAG_REAL
                        && lease_mac[hit] == item.client_mac
                        && item.now_seconds <= lease_expiry[hit]);
            end
            OP_SET_USED:
            begin
                if (hit < 0)
                    res.status = ST_MISS;
                else
                begin
                    lease_used[hit] = item.used_value;
                    lease_mac[hit] = '0;
                    lease_tag[hit] = item.used_value ? TAG_UNKNOWN : TAG_ZERO;
                end
            end
            OP_BIND:
            begin
                if (hit < 0)
                    res.status = ST_MISS;
                else
                begin
                    lease_mac[hit] = item.client_mac;
                    lease_tag[hit] = TAG_REAL;
                    lease_used[hit] = 1'b1;
                    sum = {1'b0, item.now_seconds} + {1'b0, lease_life[hit]};
                    lease_expiry[hit] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                end
            end
            OP_REQUEST:
            begin
                if (hit >= 0 && !lease_used[hit])
                    res.result_address = item.lease_address;
                else
                    res.status = ST_MISS;
            end
            OP_FIND_FREE:
            begin
                res.status = ST_MISS;
                for (int i = 0; i < lease_count; i++)
                    if (!lease_used[i])
                    begin
                        res.status = ST_DONE;
                        res.result_address = lease_addr[i];
                        break;
                    end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            lease_count = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.insert(expected_results.size(), apply_lease_op(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.result_address !== want.result_address)
                    begin
                        $error("result_address: expected %h, got %h",
                               want.result_address, out_data.result_address);
                        fail_count++;
                    end
                    if (out_data.renew_refused !== want.renew_refused)
                    begin
                        $error("renew_refused: expected %0d, got %0d",
                               want.renew_refused, out_data.renew_refused);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_results.size();
    end
endmodule
`default_nettype wire

// ===== tb/sv/tb_address_lease_table_top.sv =====
`default_nettype none
module tb_address_lease_table_top;
    import alt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    int        fail_count;
    int        pending_count;
    int        cycle_count = 0;

    // Pacing controls shared by the stimulus and the receiver processes.
    bit        send_busy_idle = 1'b1;
    bit        recv_hold = 1'b0;
    bit        recv_calm = 1'b0;

    // Addresses already loaded into the table, so that random items can hit them.
    logic [31:0] known_addrs [$];

    // A clock of 10 ns: 5 ns high, 5 ns low.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    address_lease_table_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    lease_table_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    // The receiver stalls about a third of the time, except during the calm
    // stretch, and stalls outright while a long hold-off is in force.
    always @(posedge clk)
    begin
        if (recv_hold)
            out_stall <= 1'b1;
        else if (recv_calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 33);
    end

    // Offers one item and waits until the block takes it. Random idle cycles
    // come first, so gaps land between items at every phase of a search.
    // Valid stays up after the accepting edge only until the next item or
    // idle cycle replaces it in the same time step.
    task automatic offer_item(in_item_t item);
        while (send_busy_idle && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Fills every field with random bits, then sets the operation and address.
    function automatic in_item_t random_item(logic [2:0] op, logic [31:0] addr);
        in_item_t item;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        item = raw[$bits(in_item_t)-1:0];
        item.opcode = op;
        item.lease_address = addr;
        return item;
    endfunction

    // Picks a loaded address most of the time, so that searches mostly hit.
    function automatic logic [31:0] pick_address();
        if (known_addrs.size() > 0 && $urandom_range(99) < 80)
            return known_addrs[$urandom_range(known_addrs.size() - 1)];
        return $urandom;
    endfunction

    task automatic load_entry(in_item_t item);
        known_addrs.insert(known_addrs.size(), item.lease_address);
        offer_item(item);
    endtask

    initial
    begin
        in_item_t item;
        logic [2:0] op;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Searches into an empty table miss first.
        offer_item(random_item(OP_CHECK, 32'h0));
        offer_item(random_item(OP_FIND_FREE, 32'h0));
        offer_item(random_item(OP_REQUEST, 32'hFFFF_FFFF));

        // Loads with each tag, the extreme values and both used settings.
        item = '0;
        item.opcode = OP_LOAD;
        load_entry(item);
        item = '1;
        item.opcode = OP_LOAD;
        item.mac_tag = TAG_REAL;
        load_entry(item);
        item = random_item(OP_LOAD, 32'h0A00_0001);
        item.mac_tag = TAG_ZERO;
        item.used_value = 1'b0;
        load_entry(item);
        item = random_item(OP_LOAD, 32'h0A00_0002);
        item.mac_tag = TAG_UNKNOWN;
        item.used_value = 1'b1;
        load_entry(item);
        // Tag 3 is folded into the unknown marker.
        item = random_item(OP_LOAD, 32'h0A00_0003);
        item.mac_tag = 2'd3;
        load_entry(item);
        // A duplicate address: the first matching slot must win.
        item = random_item(OP_LOAD, 32'h0);
        load_entry(item);

        // Renewal accepted, then refused after expiry and on a MAC mismatch.
        item = '1;
        item.opcode = OP_CHECK;
        offer_item(item);
        item.client_mac = 48'h0;
        offer_item(item);
        item = random_item(OP_BIND, 32'hFFFF_FFFF);
        item.now_seconds = 32'hFFFF_FFF0;
        offer_item(item);
        item = random_item(OP_BIND, 32'h0);
        item.now_seconds = 32'h0;
        offer_item(item);
        item.opcode = OP_CHECK;
        offer_item(item);
        item.now_seconds = 32'hFFFF_FFFF;
        offer_item(item);
        // Release and decline, then the request and free-address searches.
        item = random_item(OP_SET_USED, 32'h0A00_0002);
        item.used_value = 1'b0;
        offer_item(item);
        item = random_item(OP_SET_USED, 32'hFFFF_FFFF);
        item.used_value = 1'b1;
        offer_item(item);
        offer_item(random_item(OP_SET_USED, 32'h1234_5678));
        offer_item(random_item(OP_BIND, 32'h1234_5678));
        offer_item(random_item(OP_REQUEST, 32'h0A00_0002));
        offer_item(random_item(OP_REQUEST, 32'hFFFF_FFFF));
        offer_item(random_item(OP_FIND_FREE, 32'h0));
        // Unknown opcodes leave the table alone.
        offer_item(random_item(3'd6, 32'h0));
        offer_item(random_item(3'd7, 32'hFFFF_FFFF));

        // Random part: mostly operations on loaded addresses, with loads mixed
        // in until the table fills and further loads report a full table.
        for (int n = 0; n < 1700; n++)
        begin
            // A stretch with no idling on either side.
            send_busy_idle = !(n >= 300 && n < 500);
            recv_calm = (n >= 300 && n < 500);
            if (n == 900)
                recv_hold = 1'b1;
            case ($urandom_range(99)) inside
                [0:21]:  op = OP_LOAD;
                [22:37]: op = OP_CHECK;
                [38:53]: op = OP_SET_USED;
                [54:69]: op = OP_BIND;
                [70:83]: op = OP_REQUEST;
                [84:96]: op = OP_FIND_FREE;
                default: op = 3'(6 + $urandom_range(1));
            endcase
            item = random_item(op, pick_address());
            if (op == OP_LOAD)
            begin
                if ($urandom_range(99) < 30)
                    item.lease_address = $urandom;
                load_entry(item);
            end
            else
            begin
                if ($urandom_range(99) < 40)
                    item.now_seconds = $urandom_range(1000);
                offer_item(item);
            end
        end
        in_valid <= 1'b0;

        // Everything is in; let the checker count the last item, wait for the
        // last result, then watch a while longer for stray result items.
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Long receiver hold-off while the sender keeps offering: the single item
    // in the block cannot leave, so its input stall must rise.
    initial
    begin
        int held;
        held = 0;
        wait (recv_hold);
        while (held < 2000)
        begin
            @(posedge clk);
            held++;
        end
        recv_hold = 1'b0;
    end

    // Worst case is roughly 1725 items, each a full-table search, stretched by
    // random stalls on both sides; this limit leaves several times that.
    always @(posedge clk)
    begin
        if (cycle_count > 4000000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end
endmodule
`default_nettype wire
